@@ sv/first_fit_free_list_allocator_assert.svh @@
// Assertion macros for the first-fit free-list allocator.
// Depends on nothing; the including module supplies clk and rst.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define FFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FFA_ASSERT(lbl, prop, msg)
`define FFA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ sv/ffa_pkg.sv @@
// Package of the first-fit free-list allocator: item types, codes, constants.
// Used by ffa_cell and first_fit_free_list_allocator.
`default_nettype none
package ffa_pkg;
  localparam int TABLE_ENTRIES_DEF = 256;
  localparam logic [31:0] PAGE_ADD  = 32'h0000_0fff;
  localparam logic [31:0] PAGE_MASK = 32'hffff_f000;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_LOST    = 2'd2;

  localparam logic [2:0] M_NONE       = 3'd0;
  localparam logic [2:0] M_ALLOC_KEEP = 3'd1;
  localparam logic [2:0] M_ALLOC_DROP = 3'd2;
  localparam logic [2:0] M_PREV       = 3'd3;
  localparam logic [2:0] M_BOTH       = 3'd4;
  localparam logic [2:0] M_NEXT       = 3'd5;
  localparam logic [2:0] M_INSERT     = 3'd6;

  typedef struct packed {
    logic        operation;
    logic        page_round;
    logic [31:0] region_start;
    logic [31:0] region_length;
  } req_t;

  typedef struct packed {
    logic [31:0] granted_start;
    logic [1:0]  status;
    logic [31:0] free_bytes_total;
    logic [8:0]  entries_in_use;
    logic [31:0] lost_regions;
    logic [31:0] lost_bytes;
    logic [8:0]  peak_entries;
  } rsp_t;

  typedef struct packed {
    logic        cmp_en;
    logic        sel_en;
    logic        upd_en;
    logic [2:0]  mode;
    logic [31:0] size;
    logic [31:0] addr;
    logic [31:0] end_addr;
  } cell_ctrl_t;

  typedef struct packed {
    logic sel;
    logic prev_hit;
    logic next_hit;
    logic zero;
  } cell_hit_t;
endpackage
`default_nettype wire

@@ sv/ffa_cell.sv @@
// One table cell: holds one free region, compares it with the request and
// shifts or merges with its neighbors. Depends on ffa_pkg.
`default_nettype none
module ffa_cell (
  input  wire logic              clk,
  input  wire logic              valid,
  input  wire ffa_pkg::cell_ctrl_t ctrl,
  input  wire logic              l_fit_seen,
  input  wire logic              l_pos_seen,
  input  wire logic [31:0]       l_start,
  input  wire logic [31:0]       l_len,
  input  wire logic              r_pos,
  input  wire logic [31:0]       r_start,
  input  wire logic [31:0]       r_len,
  output logic                   fit_seen_out,
  output logic                   pos_seen_out,
  output logic                   pos_flag,
  output logic [31:0]            start,
  output logic [31:0]            len,
  output ffa_pkg::cell_hit_t     hit,
  output logic [31:0]            grant
);
  import ffa_pkg::*;

  logic fit, endm, nxt, eq;
  logic sel, pos, prev, pseen, pseen_ex, fseen;
  logic sel_c, pos_c, prev_c;

  assign fit_seen_out = fit | l_fit_seen;
  assign pos_seen_out = pos_flag | l_pos_seen;
  assign sel_c  = fit & ~l_fit_seen;
  assign pos_c  = pos_flag & ~l_pos_seen;
  assign prev_c = r_pos & ~pos_seen_out;

  assign hit.sel      = sel_c;
  assign hit.prev_hit = prev_c & endm;
  assign hit.next_hit = pos_c & nxt;
  assign hit.zero     = sel_c & eq;
  assign grant        = sel_c ? start : '0;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      fit      <= valid && (len >= ctrl.size);
      pos_flag <= !valid || (start > ctrl.addr);
      endm     <= valid && ((start + len) == ctrl.addr);
      nxt      <= valid && (start == ctrl.end_addr);
      eq       <= len == ctrl.size;
    end
    if (ctrl.sel_en) begin
      sel      <= sel_c;
      pos      <= pos_c;
      prev     <= prev_c;
      fseen    <= fit_seen_out;
      pseen    <= pos_seen_out;
      pseen_ex <= l_pos_seen;
    end
    if (ctrl.upd_en) begin
      case (ctrl.mode)
        M_ALLOC_KEEP: begin
          if (sel) begin
            start <= start + ctrl.size;
            len   <= len - ctrl.size;
          end
        end
        M_ALLOC_DROP: begin
          if (fseen) begin
            start <= r_start;
            len   <= r_len;
          end
        end
        M_PREV: begin
          if (prev) len <= len + ctrl.size;
        end
        M_BOTH: begin
          if (prev) begin
            len <= len + ctrl.size + r_len;
          end else if (pseen) begin
            start <= r_start;
            len   <= r_len;
          end
        end
        M_NEXT: begin
          if (pos) begin
            start <= ctrl.addr;
            len   <= len + ctrl.size;
          end
        end
        M_INSERT: begin
          if (pos) begin
            start <= ctrl.addr;
            len   <= ctrl.size;
          end else if (pseen_ex) begin
            start <= l_start;
            len   <= l_len;
          end
        end
        default: begin
        end
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/first_fit_free_list_allocator.sv @@
// Top level of the first-fit free-list allocator with coalescing.
// Depends on ffa_pkg, ffa_cell and first_fit_free_list_allocator_assert.svh.
//
//   channel   handshake            payload
//   request   start in, busy out   req  (ffa_pkg::req_t)
//   result    done out             rsp  (ffa_pkg::rsp_t)
//
// Each item passes through the steps accept, compare in every cell, select
// through the cell chain, then update. The result is shown with done in the
// cycle after the update, when busy is already low again.
// Reset clears the entry count and statistics; table contents need none.
// The receiver cannot stall; busy holds off new items while one is at work.
`default_nettype none
module first_fit_free_list_allocator #(
  parameter int TABLE_ENTRIES = ffa_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire ffa_pkg::req_t req,
  output logic               done,
  output ffa_pkg::rsp_t      rsp
);
  import ffa_pkg::*;
  `include "first_fit_free_list_allocator_assert.svh"

  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_SEL  = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0]  state;
  logic        op;
  logic [31:0] size, addr, end_addr;
  logic [CW-1:0] count, count_next, peak, peak_next;
  logic [31:0] total, total_next, lost_n, lost_n_next, lost_b, lost_b_next;
  logic        found, zero, mprev, mnext;
  logic [31:0] grant;
  logic [1:0]  status_next;
  logic [31:0] size_in;
  logic        room;
  cell_ctrl_t  ctrl;

  logic [TABLE_ENTRIES:0]   fseen, pseen;
  logic [TABLE_ENTRIES-1:0] pflag, hprev, hnext, hzero;
  logic [31:0] cst [TABLE_ENTRIES];
  logic [31:0] cln [TABLE_ENTRIES];
  logic [31:0] cgr [TABLE_ENTRIES];
  logic [31:0] grant_c;

  assign busy = state != S_IDLE;
  assign size_in = req.page_round ? ((req.region_length + PAGE_ADD) & PAGE_MASK)
                                  : req.region_length;
  assign room = count < CW'(TABLE_ENTRIES);
  assign fseen[0] = 1'b0;
  assign pseen[0] = 1'b0;

  always_comb begin
    ctrl.cmp_en   = state == S_CMP;
    ctrl.sel_en   = state == S_SEL;
    ctrl.upd_en   = state == S_UPD;
    ctrl.size     = size;
    ctrl.addr     = addr;
    ctrl.end_addr = end_addr;
    if (!op) begin
      ctrl.mode = found ? (zero ? M_ALLOC_DROP : M_ALLOC_KEEP) : M_NONE;
    end else if (mprev) begin
      ctrl.mode = mnext ? M_BOTH : M_PREV;
    end else if (mnext) begin
      ctrl.mode = M_NEXT;
    end else if (room) begin
      ctrl.mode = M_INSERT;
    end else begin
      ctrl.mode = M_NONE;
    end
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    cell_hit_t h;
    ffa_cell u_cell (
      .clk          (clk),
      .valid        (CW'(i) < count),
      .ctrl         (ctrl),
      .l_fit_seen   (fseen[i]),
      .l_pos_seen   (pseen[i]),
      .l_start      ((i == 0) ? 32'd0 : cst[(i == 0) ? 0 : i - 1]),
      .l_len        ((i == 0) ? 32'd0 : cln[(i == 0) ? 0 : i - 1]),
      .r_pos        ((i == TABLE_ENTRIES - 1) ? 1'b1
                     : pflag[(i == TABLE_ENTRIES - 1) ? i : i + 1]),
      .r_start      ((i == TABLE_ENTRIES - 1) ? 32'd0
                     : cst[(i == TABLE_ENTRIES - 1) ? i : i + 1]),
      .r_len        ((i == TABLE_ENTRIES - 1) ? 32'd0
                     : cln[(i == TABLE_ENTRIES - 1) ? i : i + 1]),
      .fit_seen_out (fseen[i+1]),
      .pos_seen_out (pseen[i+1]),
      .pos_flag     (pflag[i]),
      .start        (cst[i]),
      .len          (cln[i]),
      .hit          (h),
      .grant        (cgr[i])
    );
    assign hprev[i] = h.prev_hit;
    assign hnext[i] = h.next_hit;
    assign hzero[i] = h.zero;
  end

  always_comb begin
    grant_c = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      grant_c = grant_c | cgr[i];
    end
  end

  always_comb begin
    count_next  = count;
    total_next  = total;
    lost_n_next = lost_n;
    lost_b_next = lost_b;
    status_next = ST_OK;
    unique case (ctrl.mode) inside
      M_ALLOC_KEEP: total_next = total - size;
      M_ALLOC_DROP: begin
        total_next = total - size;
        count_next = count - CW'(1);
      end
      M_PREV, M_NEXT: total_next = total + size;
      M_BOTH: begin
        total_next = total + size;
        count_next = count - CW'(1);
      end
      M_INSERT: begin
        total_next = total + size;
        count_next = count + CW'(1);
      end
      default: begin
        if (op) begin
          status_next = ST_LOST;
          lost_n_next = lost_n + 32'd1;
          lost_b_next = lost_b + size;
        end else begin
          status_next = ST_NO_FIT;
        end
      end
    endcase
    peak_next = (peak < count_next) ? count_next : peak;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      count  <= '0;
      peak   <= '0;
      total  <= '0;
      lost_n <= '0;
      lost_b <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op       <= req.operation;
            size     <= size_in;
            addr     <= req.region_start;
            end_addr <= req.region_start + size_in;
            state    <= S_CMP;
          end
        end
        S_CMP: state <= S_SEL;
        S_SEL: begin
          found <= fseen[TABLE_ENTRIES];
          zero  <= |hzero;
          mprev <= |hprev;
          mnext <= |hnext;
          grant <= grant_c;
          state <= S_UPD;
        end
        S_UPD: begin
          count  <= count_next;
          peak   <= peak_next;
          total  <= total_next;
          lost_n <= lost_n_next;
          lost_b <= lost_b_next;
          rsp.granted_start    <= (!op && found) ? grant : 32'd0;
          rsp.status           <= status_next;
          rsp.free_bytes_total <= total_next;
          rsp.entries_in_use   <= 9'(count_next);
          rsp.lost_regions     <= lost_n_next;
          rsp.lost_bytes       <= lost_b_next;
          rsp.peak_entries     <= 9'(peak_next);
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FFA_ASSERT(a_done_idle, done |-> !busy, "result shown while an item is at work")
  `FFA_ASSERT(a_count_max, count <= CW'(TABLE_ENTRIES), "entry count above table size")
  `FFA_ASSERT(a_peak_ge, peak >= count, "peak below current entry count")
  `FFA_ASSERT(a_take, (start && !busy) |=> (busy && !done), "accepted item did not start")
  `FFA_ASSERT(a_slot, (ctrl.sel_en && room) |-> pseen[TABLE_ENTRIES], "no free slot")
  `FFA_ASSERT_ALWAYS(a_rst_idle, rst |=> (!busy && !done), "not idle after reset")
endmodule
`default_nettype wire
